[design/escape_stuffed_packet_deframer_macros.svh]
// Assertion macros for the deframer checker.
// Both sample on clk and are disabled while arst_n is low.
`ifndef ESCAPE_STUFFED_PACKET_DEFRAMER_MACROS_SVH
`define ESCAPE_STUFFED_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication
`define ESD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/esd_pkg.sv]
package esd_pkg;

	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int BYTE_W           = 8;
	localparam int LEN_W            = 7;
	localparam int ERR_W            = 16;
	localparam int CFG_IDX_W        = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP   = 1'd1;

	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;
	localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd0;

	// controller -> datapath
	typedef struct packed {
		logic set_esc;     // escape seen in normal mode
		logic clr_esc;     // byte after an escape consumed
		logic append;      // store byte (datapath handles overflow)
		logic drop;        // bad escape: discard partial packet, count error
		logic start_read;  // stop seen on non-empty packet
		logic emit_empty;  // stop seen on empty packet
		logic emit_byte;   // move prefetched byte into output register
	} esd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic after_esc;
		logic is_esc;
		logic is_stop;
		logic fill_zero;
		logic out_busy;    // output register holds a stalled result
		logic rd_last;     // byte being read out is the last of the packet
	} esd_sts_t;

endpackage

[design/esd_ctrl.sv]
module esd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  esd_pkg::esd_sts_t sts,
	output esd_pkg::esd_cmd_t cmd
);
	import esd_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// an item after an escape may produce a result, so hold it off while
	// the output register is stalled
	assign in_stall = (state_q != ST_IDLE) || (sts.out_busy && sts.after_esc);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!sts.after_esc) begin
						if (sts.is_esc) begin
							cmd.set_esc = 1'b1;
						end else begin
							cmd.append = 1'b1;
						end
					end else begin
						cmd.clr_esc = 1'b1;
						priority if (sts.is_esc) begin
							cmd.append = 1'b1;
						end else if (sts.is_stop) begin
							if (sts.fill_zero) begin
								cmd.emit_empty = 1'b1;
							end else begin
								cmd.start_read = 1'b1;
								state_d        = ST_READ;
							end
						end else begin
							cmd.drop = 1'b1;
						end
					end
				end
			end
			ST_READ: begin
				if (!sts.out_busy) begin
					cmd.emit_byte = 1'b1;
					if (sts.rd_last) begin
						state_d = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/esd_datapath.sv]
module esd_datapath #(
	parameter int BUFFER_DEPTH = esd_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [esd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [esd_pkg::BYTE_W-1:0]   cfg_data,
	input  logic [esd_pkg::BYTE_W-1:0]   rx_byte,
	input  esd_pkg::esd_cmd_t            cmd,
	output esd_pkg::esd_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [esd_pkg::BYTE_W-1:0]   packet_byte,
	output logic [esd_pkg::LEN_W-1:0]    packet_length,
	output logic                         last_of_packet,
	output logic                         empty_packet,
	output logic [esd_pkg::ERR_W-1:0]    error_count
);
	import esd_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

	logic [BYTE_W-1:0] esc_q;
	logic [BYTE_W-1:0] stop_q;
	logic              after_esc_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     len_q;
	logic [CW-1:0]     rd_cnt_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic [ERR_W-1:0]  err_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [CW-1:0]     out_len_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic [ERR_W-1:0]  out_err_q;

	logic          full;
	logic          wr_en;
	logic          rd_en;
	logic [CW-1:0] rd_nxt;
	logic [AW-1:0] rd_addr;
	logic          rd_last;
	logic          err_inc;

	assign full    = (fill_q == CW'(BUFFER_DEPTH));
	assign wr_en   = cmd.append && !full;
	assign err_inc = (cmd.drop || (cmd.append && full)) && (err_q != '1);
	assign rd_nxt  = rd_cnt_q + CW'(1);
	assign rd_last = (rd_nxt == len_q);
	assign rd_en   = cmd.start_read || cmd.emit_byte;
	assign rd_addr = cmd.start_read ? '0 : rd_nxt[AW-1:0];

	assign sts.after_esc = after_esc_q;
	assign sts.is_esc    = (rx_byte == esc_q);
	assign sts.is_stop   = (rx_byte == stop_q);
	assign sts.fill_zero = (fill_q == '0);
	assign sts.out_busy  = out_valid_q && out_stall;
	assign sts.rd_last   = rd_last;

	// packet store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= rx_byte;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= ESCAPE_RESET;
			stop_q      <= STOP_RESET;
			after_esc_q <= 1'b0;
			fill_q      <= '0;
			rd_cnt_q    <= '0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_ESCAPE: esc_q  <= cfg_data;
					REG_STOP:   stop_q <= cfg_data;
				endcase
			end

			if (cmd.set_esc) begin
				after_esc_q <= 1'b1;
			end else if (cmd.clr_esc) begin
				after_esc_q <= 1'b0;
			end

			if (cmd.drop || cmd.start_read || cmd.emit_empty) begin
				fill_q <= '0;
			end else if (cmd.append) begin
				fill_q <= full ? '0 : fill_q + CW'(1);
			end

			if (err_inc) begin
				err_q <= err_q + ERR_W'(1);
			end

			if (cmd.start_read) begin
				rd_cnt_q <= '0;
			end else if (cmd.emit_byte) begin
				rd_cnt_q <= rd_nxt;
			end

			if (cmd.emit_empty || cmd.emit_byte) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_read) begin
			len_q <= fill_q;
		end
		if (cmd.emit_empty) begin
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
			out_err_q   <= err_q;
		end else if (cmd.emit_byte) begin
			out_byte_q  <= rd_data_q;
			out_len_q   <= len_q;
			out_last_q  <= rd_last;
			out_empty_q <= 1'b0;
			out_err_q   <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign packet_byte    = out_byte_q;
	assign packet_length  = LEN_W'(out_len_q);
	assign last_of_packet = out_last_q;
	assign empty_packet   = out_empty_q;
	assign error_count    = out_err_q;

endmodule

[design/escape_stuffed_packet_deframer.sv]
// An empty packet's result is valid in the cycle after the stop byte's transfer;
// a stored packet's first byte passes through the store read register, then the output register.
// Throughput: 1 received byte per cycle when not held off; readout 1 byte per cycle from the
// store's read port while the output is not stalled. Input is held off during the whole readout.
// Reset: arst_n async, active low; clears mode, fill count, error count, output valid;
// escape_byte returns to 92, stop_byte to 0. Store contents are not cleared.
module escape_stuffed_packet_deframer #(
	parameter int BUFFER_DEPTH = esd_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write,
	input  logic [esd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [esd_pkg::BYTE_W-1:0]    cfg_data,
	// received bytes
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [esd_pkg::BYTE_W-1:0]    rx_byte,
	// packet results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [esd_pkg::BYTE_W-1:0]    packet_byte,
	output logic [esd_pkg::LEN_W-1:0]     packet_length,
	output logic                          last_of_packet,
	output logic                          empty_packet,
	output logic [esd_pkg::ERR_W-1:0]     error_count
);
	import esd_pkg::*;

	// Controller decides what each transfer does; datapath holds the config
	// registers, escape flag, packet store, counters and the output register.
	esd_cmd_t cmd;
	esd_sts_t sts;

	// Controller: IDLE takes bytes, READ streams the stored packet out.
	// Input is held off during readout, and also while a result sits stalled
	// and the next byte follows an escape (it might need the output register).
	esd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: store read is prefetched one entry ahead, so each cycle the
	// output register is free it takes one byte and the next read is issued.
	// Overflow and bad escapes empty the fill count and bump the saturating
	// error counter; the result carries the count as it stands at load.
	esd_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packet_byte    (packet_byte),
		.packet_length  (packet_length),
		.last_of_packet (last_of_packet),
		.empty_packet   (empty_packet),
		.error_count    (error_count)
	);

endmodule

[design/esd_checker.sv]
`include "escape_stuffed_packet_deframer_macros.svh"

module esd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [esd_pkg::BYTE_W-1:0]    packet_byte,
	input logic [esd_pkg::LEN_W-1:0]     packet_length,
	input logic                          last_of_packet,
	input logic                          empty_packet,
	input logic [esd_pkg::ERR_W-1:0]     error_count
);

	logic out_held;
	logic mid_burst;
	logic empty_ok;
	logic [$bits(packet_byte)+$bits(packet_length)+$bits(error_count)+1:0] out_word;

	assign out_held  = out_valid && out_stall;
	assign mid_burst = out_valid && !out_stall && !last_of_packet;
	assign empty_ok  = last_of_packet && (packet_length == '0) && (packet_byte == '0);
	assign out_word  = {packet_byte, packet_length, last_of_packet, empty_packet, error_count};

	`ESD_ASSERT_NXT(a_out_hold, out_held, out_valid, "result dropped while stalled")
	`ESD_ASSERT_NXT(a_out_stable, out_held, $stable(out_word), "stalled result changed")
	`ESD_ASSERT_IMP(a_empty_form, out_valid && empty_packet, empty_ok, "malformed empty result")
	`ESD_ASSERT_IMP(a_len_nonzero, out_valid && !empty_packet, packet_length != '0, "zero length")
	`ESD_ASSERT_NXT(a_burst, mid_burst, out_valid && $stable(packet_length), "readout broke off")

endmodule

bind escape_stuffed_packet_deframer esd_checker u_esd_checker (.*);
